// ===== hdl/stopwatch_with_lap_store_core_defines.svh =====
// Assertion macros shared by the checker.
`ifndef STOPWATCH_WITH_LAP_STORE_CORE_DEFINES_SVH
`define STOPWATCH_WITH_LAP_STORE_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SWLAP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swlap check failed");

// Next-cycle implication, disabled in reset.
`define SWLAP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swlap check failed");

`endif

// ===== hdl/swlap_pkg.sv =====
`default_nettype none

package swlap_pkg;

  localparam int LAP_DEPTH_DEF = 10;

  // one stored lap is {hours, minutes, seconds}
  localparam int HOURS_W   = 5;
  localparam int MINUTES_W = 6;
  localparam int SECONDS_W = 6;
  localparam int ENTRY_W   = HOURS_W + MINUTES_W + SECONDS_W;

  localparam logic [SECONDS_W-1:0] SEC_LAST  = SECONDS_W'(59);
  localparam logic [MINUTES_W-1:0] MIN_LAST  = MINUTES_W'(59);
  localparam logic [HOURS_W-1:0]   HOUR_LAST = HOURS_W'(23);

  typedef enum logic [2:0] {
    FUNC_TICK       = 3'd0,
    FUNC_RUN_TOGGLE = 3'd1,
    FUNC_CLEAR_TIME = 3'd2,
    FUNC_CLEAR_ALL  = 3'd3,
    FUNC_RECORD     = 3'd4,
    FUNC_READ       = 3'd5
  } func_t;

endpackage

`default_nettype wire

// ===== hdl/swlap_ram.sv =====
`default_nettype none

module swlap_ram #(
  parameter int WIDTH = swlap_pkg::ENTRY_W,
  parameter int DEPTH = swlap_pkg::LAP_DEPTH_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/stopwatch_with_lap_store_core.sv =====
`default_nettype none
// channel | signals                      | transfer when
// --------+------------------------------+-----------------------
// in      | func, lap_index              | in_valid & in_ready
// out     | hours .. lap_seconds (10)    | out_valid & out_ready
//
// One event per cycle while the output is not stalled; each event reaches the
// output through the read stage (state update, lap RAM read), then output reg.
// Time, run flag and lap count are updated in the transfer cycle; the lap RAM
// read is registered, so back-to-back record/read needs no bypass.
// rst clears time, run flag, lap count and both pipeline valids; the lap RAM is
// not cleared, entries at or above the count are never returned.
// Output stall holds the read stage, which then holds the input side.

module stopwatch_with_lap_store_core #(
  parameter int LAP_DEPTH = swlap_pkg::LAP_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] func,
  input  wire logic [3:0] lap_index,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [4:0]      hours,
  output logic [5:0]      minutes,
  output logic [5:0]      seconds,
  output logic            running,
  output logic [3:0]      lap_count,
  output logic            lap_refused,
  output logic            lap_valid,
  output logic [4:0]      lap_hours,
  output logic [5:0]      lap_minutes,
  output logic [5:0]      lap_seconds
);

  localparam int CW = $clog2(LAP_DEPTH + 1);
  localparam int AW = (LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1;
  localparam int IW = (CW > 4) ? CW : 4;
  localparam logic [CW-1:0] DEPTH_C = CW'(LAP_DEPTH);
  localparam logic [IW-1:0] DEPTH_I = IW'(LAP_DEPTH);

  // architectural state
  logic [swlap_pkg::HOURS_W-1:0]   cur_hours, cur_hours_next;
  logic [swlap_pkg::MINUTES_W-1:0] cur_minutes, cur_minutes_next;
  logic [swlap_pkg::SECONDS_W-1:0] cur_seconds, cur_seconds_next;
  logic                            run_flag, run_flag_next;
  logic [CW-1:0]                   laps_stored, laps_stored_next;

  logic                  accept;
  swlap_pkg::func_t      fcode;
  logic                  refused_next;
  logic                  hit_next;
  logic                  ram_we;
  logic                  ram_re;
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  logic [swlap_pkg::ENTRY_W-1:0] ram_wdata;
  logic [swlap_pkg::ENTRY_W-1:0] ram_rdata;
  logic [IW-1:0]         idx_w;
  logic [IW-1:0]         laps_w;

  // read stage
  logic                            s1_valid;
  logic                            s1_adv;
  logic [swlap_pkg::HOURS_W-1:0]   s1_hours;
  logic [swlap_pkg::MINUTES_W-1:0] s1_minutes;
  logic [swlap_pkg::SECONDS_W-1:0] s1_seconds;
  logic                            s1_running;
  logic [3:0]                      s1_count;
  logic                            s1_refused;
  logic                            s1_hit;

  assign fcode  = swlap_pkg::func_t'(func);
  assign s1_adv = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept = in_valid && in_ready;

  assign idx_w     = IW'(lap_index);
  assign laps_w    = IW'(laps_stored);
  assign ram_waddr = AW'(laps_stored);
  assign ram_raddr = AW'(idx_w);
  assign ram_wdata = {cur_hours, cur_minutes, cur_seconds};

  always_comb begin
    cur_hours_next   = cur_hours;
    cur_minutes_next = cur_minutes;
    cur_seconds_next = cur_seconds;
    run_flag_next    = run_flag;
    laps_stored_next = laps_stored;
    refused_next     = 1'b0;
    hit_next         = 1'b0;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    unique case (fcode)
      swlap_pkg::FUNC_TICK: begin
        if (run_flag) begin
          if (cur_seconds >= swlap_pkg::SEC_LAST) begin
            cur_seconds_next = '0;
            if (cur_minutes >= swlap_pkg::MIN_LAST) begin
              cur_minutes_next = '0;
              cur_hours_next = (cur_hours >= swlap_pkg::HOUR_LAST) ? '0
                                                                   : cur_hours + 1'b1;
            end else begin
              cur_minutes_next = cur_minutes + 1'b1;
            end
          end else begin
            cur_seconds_next = cur_seconds + 1'b1;
          end
        end
      end
      swlap_pkg::FUNC_RUN_TOGGLE: begin
        run_flag_next = !run_flag;
      end
      swlap_pkg::FUNC_CLEAR_TIME: begin
        cur_hours_next   = '0;
        cur_minutes_next = '0;
        cur_seconds_next = '0;
      end
      swlap_pkg::FUNC_CLEAR_ALL: begin
        cur_hours_next   = '0;
        cur_minutes_next = '0;
        cur_seconds_next = '0;
        laps_stored_next = '0;
      end
      swlap_pkg::FUNC_RECORD: begin
        if (laps_stored < DEPTH_C) begin
          ram_we           = accept;
          laps_stored_next = laps_stored + 1'b1;
          cur_hours_next   = '0;
          cur_minutes_next = '0;
          cur_seconds_next = '0;
        end else begin
          refused_next = 1'b1;
        end
      end
      swlap_pkg::FUNC_READ: begin
        hit_next = (idx_w < laps_w) && (idx_w < DEPTH_I);
        ram_re   = accept && hit_next;
      end
      default: begin
      end
    endcase
  end

  swlap_ram #(
    .WIDTH(swlap_pkg::ENTRY_W),
    .DEPTH(LAP_DEPTH)
  ) u_lap_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_hours   <= '0;
      cur_minutes <= '0;
      cur_seconds <= '0;
      run_flag    <= 1'b0;
      laps_stored <= '0;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        cur_hours   <= cur_hours_next;
        cur_minutes <= cur_minutes_next;
        cur_seconds <= cur_seconds_next;
        run_flag    <= run_flag_next;
        laps_stored <= laps_stored_next;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hours   <= cur_hours_next;
      s1_minutes <= cur_minutes_next;
      s1_seconds <= cur_seconds_next;
      s1_running <= run_flag_next;
      s1_count   <= 4'(laps_stored_next);
      s1_refused <= refused_next;
      s1_hit     <= hit_next;
    end
    // RAM data lands in the read stage and is masked by the hit flag here
    if (s1_adv) begin
      hours       <= s1_hours;
      minutes     <= s1_minutes;
      seconds     <= s1_seconds;
      running     <= s1_running;
      lap_count   <= s1_count;
      lap_refused <= s1_refused;
      lap_valid   <= s1_hit;
      lap_hours   <= s1_hit ? ram_rdata[swlap_pkg::ENTRY_W-1 -: swlap_pkg::HOURS_W] : '0;
      lap_minutes <= s1_hit ? ram_rdata[swlap_pkg::SECONDS_W +: swlap_pkg::MINUTES_W]
                            : '0;
      lap_seconds <= s1_hit ? ram_rdata[swlap_pkg::SECONDS_W-1:0] : '0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/swlap_checker.sv =====
`default_nettype none
`include "stopwatch_with_lap_store_core_defines.svh"

module swlap_checker #(
  parameter int LAP_DEPTH = swlap_pkg::LAP_DEPTH_DEF
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [2:0] func,
  input wire logic [3:0] lap_index,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [4:0] hours,
  input wire logic [5:0] minutes,
  input wire logic [5:0] seconds,
  input wire logic       running,
  input wire logic [3:0] lap_count,
  input wire logic       lap_refused,
  input wire logic       lap_valid,
  input wire logic [4:0] lap_hours,
  input wire logic [5:0] lap_minutes,
  input wire logic [5:0] lap_seconds
);

  localparam logic [3:0] FULL_COUNT = 4'(LAP_DEPTH);

  logic no_lap_time;

  assign no_lap_time = (lap_hours == 5'd0) && (lap_minutes == 6'd0)
                       && (lap_seconds == 6'd0);

  // a lap read that misses returns a zero time
  `SWLAP_ASSERT_IMP(a_miss_zero, clk, rst, out_valid && !lap_valid, no_lap_time)
  // refusal only happens with a full store, and never together with a read hit
  `SWLAP_ASSERT_IMP(a_refuse_full, clk, rst, out_valid && lap_refused,
                    (lap_count == FULL_COUNT) && !lap_valid)
  // a read hit needs a stored lap
  `SWLAP_ASSERT_IMP(a_hit_count, clk, rst, out_valid && lap_valid, lap_count != 4'd0)
  // stalled result holds
  `SWLAP_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready,
                    out_valid && $stable(hours) && $stable(minutes) && $stable(seconds)
                    && $stable(lap_count) && $stable(running))
  // offered event holds until its transfer
  `SWLAP_ASSERT_NXT(a_in_hold, clk, rst, in_valid && !in_ready,
                    in_valid && $stable(func) && $stable(lap_index))

endmodule

bind stopwatch_with_lap_store_core swlap_checker #(.LAP_DEPTH(LAP_DEPTH)) u_swlap_checker (.*);

`default_nettype wire
